// ----- hdl/usp_pkg.sv -----
// ----------------------------------------------------------------------------
// usp_pkg
// Shared types, codes and character helpers for the URL scheme/host/port
// parser: result and command bundles, phase codes, scheme tables.
// ----------------------------------------------------------------------------
package usp_pkg;

    // result kinds
    localparam logic [1:0] KIND_HOST   = 2'd0;
    localparam logic [1:0] KIND_DOC    = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;

    // report status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_MATCH = 2'd1;
    localparam logic [1:0] ST_BAD_PROTO = 2'd2;
    localparam logic [1:0] ST_BAD_PORT = 2'd3;

    // protocol codes
    localparam logic [1:0] PROTO_HTTP  = 2'd0;
    localparam logic [1:0] PROTO_HTTPS = 2'd1;
    localparam logic [1:0] PROTO_FTP   = 2'd2;

    // character codes
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // port limits
    localparam logic [16:0] PORT_MAX = 17'd65535;
    localparam logic [16:0] PORT_SAT = 17'd65536;

    // longest scheme name
    localparam logic [2:0] SCHEME_MAX_LEN = 3'd5;

    // results one character can cause
    localparam int MAX_RES = 3;

    // parser phases, one-hot
    typedef enum logic [8:0] {
        PH_SCHEME    = 9'b000000001,
        PH_SLASH1    = 9'b000000010,
        PH_SLASH2    = 9'b000000100,
        PH_HOSTFIRST = 9'b000001000,
        PH_HOST      = 9'b000010000,
        PH_COLON     = 9'b000100000,
        PH_PORT      = 9'b001000000,
        PH_DOC       = 9'b010000000,
        PH_FAIL      = 9'b100000000
    } usp_phase_t;

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_char;
        logic [1:0]  status;
        logic [1:0]  protocol;
        logic [15:0] port;
        logic        end_of_run;
    } usp_res_t;

    // everything one character causes
    typedef struct packed {
        usp_res_t [MAX_RES-1:0] slot;
        logic [1:0]             cnt;
    } usp_cmd_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c >= 8'h09 && c <= 8'h0D) || c == CH_SPACE;
    endfunction

    function automatic logic is_host(input logic [7:0] c);
        return is_letter(c) || is_digit(c) || c == CH_DOT || c == CH_DASH;
    endfunction

    // upper-case letter of scheme idx at position pos, zero past its end
    function automatic logic [7:0] scheme_char(input logic [1:0] idx, input logic [2:0] pos);
        logic [7:0] r;
        r = 8'h00;
        unique case (idx)
            PROTO_HTTP, PROTO_HTTPS:
            begin
                unique case (pos)
                    3'd0: r = 8'h48;
                    3'd1: r = 8'h54;
                    3'd2: r = 8'h54;
                    3'd3: r = 8'h50;
                    3'd4: r = (idx == PROTO_HTTPS) ? 8'h53 : 8'h00;
                    default: r = 8'h00;
                endcase
            end
            PROTO_FTP:
            begin
                unique case (pos)
                    3'd0: r = 8'h46;
                    3'd1: r = 8'h54;
                    3'd2: r = 8'h50;
                    default: r = 8'h00;
                endcase
            end
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] scheme_len(input logic [1:0] idx);
        logic [2:0] r;
        unique case (idx)
            PROTO_HTTP:  r = 3'd4;
            PROTO_HTTPS: r = 3'd5;
            PROTO_FTP:   r = 3'd3;
            default:     r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] default_port(input logic [1:0] proto);
        logic [15:0] r;
        unique case (proto)
            PROTO_HTTP:  r = 16'd80;
            PROTO_HTTPS: r = 16'd443;
            PROTO_FTP:   r = 16'd21;
            default:     r = 16'd0;
        endcase
        return r;
    endfunction

    function automatic usp_res_t mk_char(input logic [1:0] kind, input logic [7:0] c);
        usp_res_t r;
        r            = '0;
        r.kind       = kind;
        r.out_char   = c;
        return r;
    endfunction

endpackage

// ----- hdl/url_scheme_host_port_parser.sv -----
// ----------------------------------------------------------------------------
// url_scheme_host_port_parser
// Streaming URL recognizer: scheme (HTTP, HTTPS, FTP), host, optional port
// and document, one character per item, with host and document characters
// echoed as tagged results and a closing report per URL.
//
//   channel | handshake            | fields
//   --------+----------------------+--------------------------------------
//   in      | in_valid / in_stall  | char_code, last_char
//   out     | out_valid / out_stall| kind, out_char, status, protocol,
//           |                      | port, end_of_run
//
// One character is taken per cycle while the command queue has room.
// Each result item goes out on its own through the output register, so a
// character that causes two or three results (a trailing colon, the final
// report) holds the serializer until all have left; the queue absorbs the
// difference. A result passes the queue storage, then the output register.
// Reset puts the recognizer at the start of a URL; it returns there after
// every last character. out_stall only holds the output register and the
// queue; in_stall rises when the queue is full.
// ----------------------------------------------------------------------------
module url_scheme_host_port_parser
    import usp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    input  logic        last_char,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  out_char,
    output logic [1:0]  status,
    output logic [1:0]  protocol,
    output logic [15:0] port,
    output logic        end_of_run
);

    logic     accept;
    logic     push;
    logic     pop;
    logic     full;
    logic     rd_valid;
    usp_cmd_t wr_cmd;
    usp_cmd_t rd_cmd;
    usp_res_t out_res;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    // recognizer
    usp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_code (char_code),
        .last_char (last_char),
        .push      (push),
        .cmd       (wr_cmd)
    );

    // command queue
    usp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_data  (wr_cmd),
        .pop      (pop),
        .full     (full),
        .rd_valid (rd_valid),
        .rd_data  (rd_cmd)
    );

    // result serializer
    usp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_valid  (rd_valid),
        .rd_data   (rd_cmd),
        .pop       (pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign kind       = out_res.kind;
    assign out_char   = out_res.out_char;
    assign status     = out_res.status;
    assign protocol   = out_res.protocol;
    assign port       = out_res.port;
    assign end_of_run = out_res.end_of_run;

    // queued commands always carry at least one result
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid |-> (rd_cmd.cnt != 2'd0))
    else $error("queued command with no results");

    // a full queue never takes a push
    assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
    else $error("push into full queue");

    // a report is exactly the item closing a url
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((kind == KIND_REPORT) == end_of_run))
    else $error("report kind and end of run disagree");

    // an ok report never carries port zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && end_of_run && status == ST_OK) |-> (port != 16'd0))
    else $error("ok report with port zero");

endmodule

// ----- hdl/usp_front.sv -----
// ----------------------------------------------------------------------------
// usp_front
// Character classifier and recognizer state machine. Takes one character
// per accepted cycle and turns it into a command of zero to three results.
// ----------------------------------------------------------------------------
module usp_front
    import usp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] char_code,
    input  logic       last_char,
    output logic       push,
    output usp_cmd_t   cmd
);

    usp_phase_t  phase_reg, phase_next;
    logic [2:0]  pos_reg, pos_next;
    logic [2:0]  cand_reg, cand_next;
    logic        overlong_reg, overlong_next;
    logic [16:0] acc_reg, acc_next;
    logic        given_reg, given_next;

    logic [7:0]  upper;
    logic [20:0] acc_x10;
    logic [1:0]  n;
    logic        run_ok;
    usp_res_t    rep;

    // port accumulator times ten plus the new digit
    assign acc_x10 = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                   + {17'b0, char_code[3:0]};

    // case-folded letter
    assign upper = (char_code >= 8'h61) ? char_code - 8'd32 : char_code;

    // next state and emitted results
    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        cand_next     = cand_reg;
        overlong_next = overlong_reg;
        acc_next      = acc_reg;
        given_next    = given_reg;
        cmd           = '0;
        n             = 2'd0;
        run_ok        = 1'b0;
        rep           = '0;

        unique case (phase_reg)
            PH_SCHEME:
            begin
                if (is_letter(char_code))
                begin
                    if (pos_reg >= SCHEME_MAX_LEN)
                    begin
                        overlong_next = 1'b1;
                    end
                    else
                    begin
                        for (int i = 0; i < MAX_RES; i++)
                        begin
                            if (pos_reg >= scheme_len(2'(i))
                                || scheme_char(2'(i), pos_reg) != upper)
                            begin
                                cand_next[i] = 1'b0;
                            end
                        end
                        pos_next = pos_reg + 3'd1;
                    end
                end
                else if (char_code == CH_COLON && pos_reg != 3'd0)
                begin
                    for (int i = 0; i < MAX_RES; i++)
                    begin
                        if (scheme_len(2'(i)) != pos_reg || overlong_reg)
                        begin
                            cand_next[i] = 1'b0;
                        end
                    end
                    phase_next = PH_SLASH1;
                end
                else
                begin
                    phase_next = PH_FAIL;
                end
            end
            PH_SLASH1:
            begin
                phase_next = (char_code == CH_SLASH) ? PH_SLASH2 : PH_FAIL;
            end
            PH_SLASH2:
            begin
                phase_next = (char_code == CH_SLASH) ? PH_HOSTFIRST : PH_FAIL;
            end
            PH_HOSTFIRST:
            begin
                if (is_host(char_code))
                begin
                    phase_next = PH_HOST;
                    cmd.slot[n] = mk_char(KIND_HOST, char_code);
                    n = n + 2'd1;
                end
                else
                begin
                    phase_next = PH_FAIL;
                end
            end
            PH_HOST:
            begin
                if (is_host(char_code))
                begin
                    cmd.slot[n] = mk_char(KIND_HOST, char_code);
                    n = n + 2'd1;
                end
                else if (char_code == CH_COLON)
                begin
                    phase_next = PH_COLON;
                end
                else if (is_space(char_code))
                begin
                    phase_next = PH_FAIL;
                end
                else
                begin
                    phase_next = PH_DOC;
                    cmd.slot[n] = mk_char(KIND_DOC, char_code);
                    n = n + 2'd1;
                end
            end
            PH_COLON:
            begin
                if (is_digit(char_code))
                begin
                    phase_next = PH_PORT;
                    given_next = 1'b1;
                    acc_next   = {13'b0, char_code[3:0]};
                end
                else
                begin
                    // colon was document text after all
                    cmd.slot[n] = mk_char(KIND_DOC, CH_COLON);
                    n = n + 2'd1;
                    if (is_space(char_code))
                    begin
                        phase_next = PH_FAIL;
                    end
                    else
                    begin
                        phase_next = PH_DOC;
                        cmd.slot[n] = mk_char(KIND_DOC, char_code);
                        n = n + 2'd1;
                    end
                end
            end
            PH_PORT:
            begin
                if (is_digit(char_code))
                begin
                    acc_next = (acc_x10 > {4'b0, PORT_MAX}) ? PORT_SAT : acc_x10[16:0];
                end
                else if (is_space(char_code))
                begin
                    phase_next = PH_FAIL;
                end
                else
                begin
                    phase_next = PH_DOC;
                    cmd.slot[n] = mk_char(KIND_DOC, char_code);
                    n = n + 2'd1;
                end
            end
            PH_DOC:
            begin
                if (is_space(char_code))
                begin
                    phase_next = PH_FAIL;
                end
                else
                begin
                    cmd.slot[n] = mk_char(KIND_DOC, char_code);
                    n = n + 2'd1;
                end
            end
            PH_FAIL:
            begin
                phase_next = PH_FAIL;
            end
            default:
            begin
                phase_next = PH_FAIL;
            end
        endcase

        // final report on the last character
        if (last_char)
        begin
            if (phase_next == PH_COLON)
            begin
                cmd.slot[n] = mk_char(KIND_DOC, CH_COLON);
                n = n + 2'd1;
                phase_next = PH_DOC;
            end
            run_ok = (phase_next == PH_HOST) || (phase_next == PH_PORT)
                  || (phase_next == PH_DOC);
            rep.kind       = KIND_REPORT;
            rep.end_of_run = 1'b1;
            if (!run_ok)
            begin
                rep.status = ST_NO_MATCH;
            end
            else if (cand_next == 3'b000)
            begin
                rep.status = ST_BAD_PROTO;
            end
            else
            begin
                rep.protocol = cand_next[0] ? PROTO_HTTP
                             : cand_next[1] ? PROTO_HTTPS : PROTO_FTP;
                if (!given_next)
                begin
                    rep.status = ST_OK;
                    rep.port   = default_port(rep.protocol);
                end
                else if (acc_next == 17'd0 || acc_next[16])
                begin
                    rep.status   = ST_BAD_PORT;
                    rep.protocol = PROTO_HTTP;
                end
                else
                begin
                    rep.status = ST_OK;
                    rep.port   = acc_next[15:0];
                end
            end
            cmd.slot[n] = rep;
            n = n + 2'd1;

            // back to the start for the next url
            phase_next    = PH_SCHEME;
            pos_next      = 3'd0;
            cand_next     = 3'b111;
            overlong_next = 1'b0;
            acc_next      = 17'd0;
            given_next    = 1'b0;
        end

        cmd.cnt = n;
    end

    assign push = accept && (n != 2'd0);

    // recognizer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SCHEME;
            pos_reg      <= 3'd0;
            cand_reg     <= 3'b111;
            overlong_reg <= 1'b0;
            acc_reg      <= 17'd0;
            given_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            cand_reg     <= cand_next;
            overlong_reg <= overlong_next;
            acc_reg      <= acc_next;
            given_reg    <= given_next;
        end
    end

endmodule

// ----- hdl/usp_fifo.sv -----
// ----------------------------------------------------------------------------
// usp_fifo
// Short command queue between the recognizer and the result serializer.
// ----------------------------------------------------------------------------
module usp_fifo
    import usp_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  usp_cmd_t wr_data,
    input  logic     pop,
    output logic     full,
    output logic     rd_valid,
    output usp_cmd_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    usp_cmd_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- hdl/usp_back.sv -----
// ----------------------------------------------------------------------------
// usp_back
// Result serializer: walks the slots of the queued command and presents
// one result item per cycle through an output register while out_stall is low.
// ----------------------------------------------------------------------------
module usp_back
    import usp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     rd_valid,
    input  usp_cmd_t rd_data,
    output logic     pop,
    input  logic     out_stall,
    output logic     out_valid,
    output usp_res_t out_res
);

    logic       out_valid_reg, out_valid_next;
    usp_res_t   res_reg;
    logic [1:0] idx_reg, idx_next;
    logic       load;
    logic       last_slot;

    // output register free or being emptied
    assign load      = !out_valid_reg || !out_stall;
    assign last_slot = (idx_reg == rd_data.cnt - 2'd1);
    assign pop       = load && rd_valid && last_slot;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            out_valid_next = rd_valid;
            if (rd_valid)
            begin
                idx_next = last_slot ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load && rd_valid)
        begin
            res_reg <= rd_data.slot[idx_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

endmodule
